// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion, clocked, also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/tmta_pkg.sv -----
// ----------------------------------------------------------------------------
// tmta_pkg
// Types and constants of the two-marker tracker: CORDIC table, angle limits,
// register addresses.
// ----------------------------------------------------------------------------
package tmta_pkg;

   localparam int COORD_W     = 16;
   localparam int ANGLE_W     = 15;
   localparam int RATE_W      = 21;
   localparam int FRATE_W     = 10;
   localparam int RADIUS_W    = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_W    = 28;
   localparam int Z_W         = 19;
   localparam int MUL_W       = 17;

   localparam logic signed [Z_W-1:0] HALF_PI_Q13 = 19'sd12868;
   localparam logic signed [35:0]    RATE_LIMIT  = 36'sd804248;

   // register indexes
   localparam logic [2:0] REG_FRAME_RATE = 3'd0;
   localparam logic [2:0] REG_RADIUS     = 3'd1;
   localparam logic [2:0] REG_START_X0   = 3'd2;
   localparam logic [2:0] REG_START_Y0   = 3'd3;
   localparam logic [2:0] REG_START_X1   = 3'd4;
   localparam logic [2:0] REG_START_Y1   = 3'd5;

   typedef struct packed {
      logic                    done;
      logic signed [Z_W-1:0]   z;
   } cordic_status_type;

   // arctangent of 2^-i in units of 2^-16 rad
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [3:0] i);
      logic signed [Z_W-1:0] v;
      unique case (i)
         4'd0:  v = 19'sd51472;
         4'd1:  v = 19'sd30386;
         4'd2:  v = 19'sd16055;
         4'd3:  v = 19'sd8150;
         4'd4:  v = 19'sd4091;
         4'd5:  v = 19'sd2047;
         4'd6:  v = 19'sd1024;
         4'd7:  v = 19'sd512;
         4'd8:  v = 19'sd256;
         4'd9:  v = 19'sd128;
         4'd10: v = 19'sd64;
         4'd11: v = 19'sd32;
         4'd12: v = 19'sd16;
         4'd13: v = 19'sd8;
         4'd14: v = 19'sd4;
         default: v = 19'sd2;
      endcase
      return v;
   endfunction

endpackage

// ----- design/tmta_cordic.sv -----
// ----------------------------------------------------------------------------
// tmta_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tmta_cordic (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [tmta_pkg::CORDIC_W-1:0]   x_start,
   input  logic signed [tmta_pkg::CORDIC_W-1:0]   y_start,
   output tmta_pkg::cordic_status_type            status
);
   import tmta_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, y_ff, xs, ys;
   logic signed [Z_W-1:0]      z_ff;
   logic [3:0]                 step_ff;
   logic                       busy_ff, done_ff;

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 4'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff    <= x_start;
            y_ff    <= y_start;
            z_ff    <= '0;
            step_ff <= 4'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!y_ff[CORDIC_W-1]) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_entry(step_ff);
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_entry(step_ff);
            end
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.done = done_ff;
   assign status.z    = z_ff;

endmodule

// ----- design/two_marker_tracker_angle.sv -----
// ----------------------------------------------------------------------------
// two_marker_tracker_angle
// Tracks two markers over camera frames and reports line angle and rate.
// ----------------------------------------------------------------------------
// Usage:
//  req_ stream carries one detected dot per transfer (tuser = dot_present,
//  tdata = dot_x, dot_y, tlast = frame end). rsp_ stream gives one result per
//  frame (tuser = matched, tdata = angle, rate, marker positions).
//  csr_ APB port: frame_rate, match_radius, start_x0/y0/x1/y1 (byte addr 4*i);
//  a start write loads the tracked coordinate at once.
// Sequencing: one shared 17x17 multiplier and a small sequencer; a dot goes
//  through accept, radius square, then two squares and a compare per marker,
//  an item without a dot through accept and radius square; a new item is
//  accepted only in idle. A frame end adds matching, angle setup, the CORDIC
//  run, rate product and output load; no CORDIC run when x1-x0 is not positive.
// Reset clears the tracked positions, previous angle and frame state and
//  loads frame_rate 30, match_radius 20.
// A stalled receiver holds the result in the output register; the next frame
//  end waits until it is taken, dots are accepted meanwhile.
// ----------------------------------------------------------------------------
module two_marker_tracker_angle #(
   parameter int MAX_DOTS        = 256,
   parameter int COORD_FRAC_BITS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // dot_x[15:0], dot_y[31:16]
   input  logic         req_tuser,   // dot_present
   input  logic         req_tlast,   // frame_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // angle[14:0], angle_rate[35:15], marker0_x[51:36], marker0_y[67:52],
   // marker1_x[83:68], marker1_y[99:84], zero[103:100]
   output logic [103:0] rsp_tdata,
   output logic         rsp_tuser,   // matched
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import tmta_pkg::*;

   localparam int CNT_W = $clog2(MAX_DOTS + 1);
   localparam int IDX_W = (MAX_DOTS > 1) ? $clog2(MAX_DOTS) : 1;
   localparam int RS_W  = RADIUS_W + COORD_FRAC_BITS;
   localparam int LIM_W = 2 * RS_W;
   localparam int ACC_W = 2 * MUL_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LIM, ST_SQX, ST_SQY, ST_CMP, ST_FRAME,
      ST_ANGLE, ST_CORDIC, ST_RATE, ST_OUT
   } state_type;

   state_type                 state_ff;
   logic [FRATE_W-1:0]        frame_rate_ff;
   logic [RADIUS_W-1:0]       radius_ff;
   logic [COORD_W-1:0]        pos_ff [4];
   logic [COORD_W-1:0]        best_xy_ff [4];
   logic [LIM_W-1:0]          best_dist_ff [2];
   logic [IDX_W-1:0]          best_idx_ff [2];
   logic [1:0]                best_valid_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic signed [ANGLE_W-1:0] prev_angle_ff, angle_ff;
   logic [COORD_W-1:0]        dot_x_ff, dot_y_ff;
   logic                      process_ff, last_ff, mk_ff, matched_ff;
   logic [LIM_W-1:0]          lim_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic signed [ACC_W-1:0]   prod_ff;
   logic                      rsp_valid_ff, rsp_user_ff;
   logic [103:0]              rsp_data_ff;

   logic signed [MUL_W-1:0]   mul_a, mul_b, ex, ey, den, num, diff;
   logic signed [ACC_W-1:0]   prod;
   logic [LIM_W-1:0]          bound;
   logic                      csr_wr, cordic_start, slot_free;
   logic signed [CORDIC_W-1:0] cx, cy;
   cordic_status_type         cst;
   logic signed [Z_W-1:0]     z_round;
   logic signed [ACC_W-1:0]   rate_wide;
   logic signed [RATE_W-1:0]  rate_sat;

   // shared multiplier operand selection
   assign ex   = $signed({1'b0, dot_x_ff}) - $signed({1'b0, pos_ff[{mk_ff, 1'b0}]});
   assign ey   = $signed({1'b0, dot_y_ff}) - $signed({1'b0, pos_ff[{mk_ff, 1'b1}]});
   assign diff = MUL_W'(angle_ff) - MUL_W'(prev_angle_ff);

   always_comb begin
      unique case (state_ff)
         ST_LIM: begin
            mul_a = $signed(MUL_W'(radius_ff) << COORD_FRAC_BITS);
            mul_b = mul_a;
         end
         ST_SQX: begin
            mul_a = ex;
            mul_b = ex;
         end
         ST_SQY: begin
            mul_a = ey;
            mul_b = ey;
         end
         default: begin
            mul_a = diff;
            mul_b = $signed(MUL_W'(frame_rate_ff));
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign bound = best_valid_ff[mk_ff] ? best_dist_ff[mk_ff] : lim_ff;
   assign den   = $signed({1'b0, pos_ff[2]}) - $signed({1'b0, pos_ff[0]});
   assign num   = $signed({1'b0, pos_ff[1]}) - $signed({1'b0, pos_ff[3]});
   assign cx    = CORDIC_W'(den) <<< 8;
   assign cy    = CORDIC_W'(num) <<< 8;
   assign cordic_start = (state_ff == ST_ANGLE) && (den > 0);

   tmta_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .x_start (cx),
      .y_start (cy),
      .status  (cst)
   );

   assign z_round   = (cst.z + 19'sd4) >>> 3;
   assign rate_wide = (prod_ff + ACC_W'(16)) >>> 5;
   always_comb begin
      if (rate_wide > ACC_W'(RATE_LIMIT))        rate_sat = RATE_W'(RATE_LIMIT);
      else if (rate_wide < -ACC_W'(RATE_LIMIT))  rate_sat = -RATE_W'(RATE_LIMIT);
      else                                       rate_sat = rate_wide[RATE_W-1:0];
   end

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_FRAME_RATE: csr_prdata = 32'(frame_rate_ff);
         REG_RADIUS:     csr_prdata = 32'(radius_ff);
         REG_START_X0:   csr_prdata = 32'(pos_ff[0]);
         REG_START_Y0:   csr_prdata = 32'(pos_ff[1]);
         REG_START_X1:   csr_prdata = 32'(pos_ff[2]);
         REG_START_Y1:   csr_prdata = 32'(pos_ff[3]);
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frame_rate_ff <= FRATE_W'(30);
         radius_ff     <= RADIUS_W'(20);
         for (int k = 0; k < 4; k++) pos_ff[k] <= '0;
         best_valid_ff <= '0;
         cnt_ff        <= '0;
         prev_angle_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         mk_ff         <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) rsp_valid_ff <= 1'b0;
         if (csr_wr) begin
            unique case (csr_paddr[4:2])
               REG_FRAME_RATE: frame_rate_ff <= csr_pwdata[FRATE_W-1:0];
               REG_RADIUS:     radius_ff     <= csr_pwdata[RADIUS_W-1:0];
               REG_START_X0:   pos_ff[0]     <= csr_pwdata[COORD_W-1:0];
               REG_START_Y0:   pos_ff[1]     <= csr_pwdata[COORD_W-1:0];
               REG_START_X1:   pos_ff[2]     <= csr_pwdata[COORD_W-1:0];
               REG_START_Y1:   pos_ff[3]     <= csr_pwdata[COORD_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  dot_x_ff   <= req_tdata[15:0];
                  dot_y_ff   <= req_tdata[31:16];
                  process_ff <= req_tuser && (cnt_ff < CNT_W'(MAX_DOTS));
                  last_ff    <= req_tlast;
                  mk_ff      <= 1'b0;
                  state_ff   <= ST_LIM;
               end
            end
            ST_LIM: begin
               lim_ff <= prod[LIM_W-1:0];
               if (process_ff)   state_ff <= ST_SQX;
               else if (last_ff) state_ff <= ST_FRAME;
               else              state_ff <= ST_IDLE;
            end
            ST_SQX: begin
               acc_ff   <= prod;
               state_ff <= ST_SQY;
            end
            ST_SQY: begin
               acc_ff   <= acc_ff + ACC_W'(prod);
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               // strict compare: a tie keeps the earlier dot
               if (acc_ff < ACC_W'(bound)) begin
                  best_dist_ff[mk_ff]       <= acc_ff[LIM_W-1:0];
                  best_valid_ff[mk_ff]      <= 1'b1;
                  best_idx_ff[mk_ff]        <= cnt_ff[IDX_W-1:0];
                  best_xy_ff[{mk_ff, 1'b0}] <= dot_x_ff;
                  best_xy_ff[{mk_ff, 1'b1}] <= dot_y_ff;
               end
               if (!mk_ff) begin
                  mk_ff    <= 1'b1;
                  state_ff <= ST_SQX;
               end else begin
                  cnt_ff   <= cnt_ff + CNT_W'(1);
                  state_ff <= last_ff ? ST_FRAME : ST_IDLE;
               end
            end
            ST_FRAME: begin
               matched_ff <= best_valid_ff[0] && best_valid_ff[1] &&
                             (best_idx_ff[0] != best_idx_ff[1]);
               if (best_valid_ff[0] && best_valid_ff[1] &&
                   (best_idx_ff[0] != best_idx_ff[1])) begin
                  for (int k = 0; k < 4; k++) pos_ff[k] <= best_xy_ff[k];
               end
               state_ff <= ST_ANGLE;
            end
            ST_ANGLE: begin
               if (den > 0) begin
                  state_ff <= ST_CORDIC;
               end else begin
                  angle_ff <= ANGLE_W'(HALF_PI_Q13);
                  state_ff <= ST_RATE;
               end
            end
            ST_CORDIC: begin
               if (cst.done) begin
                  if (z_round > HALF_PI_Q13)       angle_ff <= ANGLE_W'(HALF_PI_Q13);
                  else if (z_round < -HALF_PI_Q13) angle_ff <= -ANGLE_W'(HALF_PI_Q13);
                  else                             angle_ff <= z_round[ANGLE_W-1:0];
                  state_ff <= ST_RATE;
               end
            end
            ST_RATE: begin
               prod_ff  <= prod;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_user_ff   <= matched_ff;
                  rsp_data_ff   <= {4'd0, pos_ff[3], pos_ff[2], pos_ff[1], pos_ff[0],
                                    rate_sat, angle_ff};
                  prev_angle_ff <= angle_ff;
                  best_valid_ff <= '0;
                  cnt_ff        <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- design/tmta_checker.sv -----
// ----------------------------------------------------------------------------
// tmta_checker
// Port-level checks of the two-marker tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmta_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic         csr_pready
);
   logic signed [14:0] angle;
   assign angle = $signed(rsp_tdata[14:0]);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "ready right after transfer")
   `ASSERT_CLK(a_angle_range, clock, reset, rsp_tvalid |-> (angle <= 15'sd12868) && (angle >= -15'sd12868), "angle out of range")
   `ASSERT_ALWAYS(a_reset_clear, clock, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")
   `ASSERT_CLK(a_pready, clock, reset, csr_pready, "pready low")

endmodule

bind two_marker_tracker_angle tmta_checker u_tmta_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
